FILE: rtl/core/anv_pkg.sv
`timescale 1ns / 1ps
package anv_pkg;

  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [7:0] MIN_LEN_RST  = 8'd3;
  localparam logic [7:0] MAX_LEN_RST  = 8'd32;
  localparam logic [7:0] PREM_LEN_RST = 8'd8;

  typedef enum logic [1:0] {
    REG_MIN_LEN  = 2'd0,
    REG_MAX_LEN  = 2'd1,
    REG_PREM_LEN = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] min_len;
    logic [7:0] max_len;
    logic [7:0] prem_len;
  } anv_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] tot_cnt;
    logic [CNT_W-1:0] seg_cnt;
    logic [7:0]       prev_byte;
    logic             failed;
    logic             letters;
  } anv_state_t;

  localparam anv_state_t STATE_RST = '{
    tot_cnt:   '0,
    seg_cnt:   '0,
    prev_byte: '0,
    failed:    1'b0,
    letters:   1'b1
  };

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_head(input logic [7:0] b);
    return is_lower(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_tail(input logic [7:0] b);
    return is_head(b) || is_digit(b);
  endfunction

  function automatic logic is_body(input logic [7:0] b);
    return is_tail(b) || (b == CH_HYPHEN);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

FILE: rtl/core/anv_if.sv
`timescale 1ns / 1ps
interface anv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

interface anv_out_if;
  logic valid;
  logic ready;
  logic name_valid;
  logic name_premium;

  modport source (output valid, output name_valid, output name_premium, input ready);
  modport sink (input valid, input name_valid, input name_premium, output ready);
endinterface

FILE: rtl/core/anv_step.sv
`timescale 1ns / 1ps
module anv_step (
  input  anv_pkg::anv_cfg_t   cfg,
  input  anv_pkg::anv_state_t cur,
  input  logic [7:0]          char_byte,
  input  logic                is_last,
  output anv_pkg::anv_state_t nxt,
  output logic                name_valid,
  output logic                name_premium
);
  import anv_pkg::*;

  logic             fail;
  logic             letters;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] seg;
  logic [CNT_W-1:0] min_ext;
  logic [CNT_W-1:0] max_ext;
  logic [CNT_W-1:0] prem_ext;

  assign min_ext  = {1'b0, cfg.min_len};
  assign max_ext  = {1'b0, cfg.max_len};
  assign prem_ext = {1'b0, cfg.prem_len};

  always_comb begin
    fail    = cur.failed;
    letters = cur.letters && is_lower(char_byte);
    total   = sat_inc(cur.tot_cnt);
    seg     = cur.seg_cnt;

    if (char_byte == CH_DOT) begin
      // close the segment before the dot; a dot on the last byte leaves an empty one
      if (seg == '0 || seg < min_ext || !is_tail(cur.prev_byte)) fail = 1'b1;
      if (is_last) fail = 1'b1;
      seg = '0;
    end else begin
      if (seg == '0) begin
        if (!is_head(char_byte)) fail = 1'b1;
      end else begin
        if (!is_body(char_byte)) fail = 1'b1;
      end
      seg = sat_inc(seg);
      if (is_last && (seg < min_ext || !is_tail(char_byte))) fail = 1'b1;
    end

    name_valid   = !fail && total >= min_ext && total <= max_ext;
    name_premium = letters && total >= min_ext && total <= prem_ext;

    if (is_last) begin
      nxt = STATE_RST;
    end else begin
      nxt.tot_cnt   = total;
      nxt.seg_cnt   = seg;
      nxt.prev_byte = char_byte;
      nxt.failed    = fail;
      nxt.letters   = letters;
    end
  end

endmodule

FILE: rtl/core/account_name_validator.sv
`timescale 1ns / 1ps
// Dotted account name syntax checker.
//
// in_ch carries a name one byte per request, with is_last set on its final
// byte. out_ch carries one result per name (name_valid, name_premium), sent
// only for the final byte; other bytes produce nothing on out_ch.
// cfg_we/cfg_index/cfg_wdata write min_length (0), max_length (1) and
// premium_max_length (2); index 3 is ignored. Write them only while idle.
//
// Throughput is one byte per cycle unless a final byte waits on a full
// output register: a byte is captured in the input register, then
// classified and folded into the name state as it leaves that register,
// and the result for a final byte lands in the output register, which
// drives out_ch.valid. The single pass through anv_step sets the cycle time.
//
// Reset clears the pipeline, starts a fresh name and loads the register
// defaults 3, 32 and 8. When out_ch stalls, the result holds in the output
// register; a final byte waits in the input register and in_ch.ready drops
// only while both are full; non-final bytes keep flowing past a held result.
module account_name_validator (
  input  logic                  clk,
  input  logic                  rst_n,
  anv_in_if.sink                in_ch,
  anv_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);
  import anv_pkg::*;

  anv_cfg_t   cfg_r;
  anv_state_t st_r, st_nxt;

  // input register
  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       stg_adv;

  // result register
  logic       out_v_r;
  logic       res_valid_r, res_prem_r;
  logic       res_valid, res_prem;
  logic       out_free;

  // configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len  <= MIN_LEN_RST;
      cfg_r.max_len  <= MAX_LEN_RST;
      cfg_r.prem_len <= PREM_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MIN_LEN:  cfg_r.min_len  <= cfg_wdata;
        REG_MAX_LEN:  cfg_r.max_len  <= cfg_wdata;
        REG_PREM_LEN: cfg_r.prem_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a staged byte advances unless it is final and the result slot stays full
  assign out_free    = !out_v_r || out_ch.ready;
  assign stg_adv     = stg_v_r && (!stg_last_r || out_free);
  assign in_ch.ready = !stg_v_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_byte_r <= in_ch.char_byte;
      stg_last_r <= in_ch.is_last;
    end
  end

  anv_step u_step (
    .cfg          (cfg_r),
    .cur          (st_r),
    .char_byte    (stg_byte_r),
    .is_last      (stg_last_r),
    .nxt          (st_nxt),
    .name_valid   (res_valid),
    .name_premium (res_prem)
  );

  // name state; advance once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RST;
    end else if (stg_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_adv && stg_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_last_r) begin
      res_valid_r <= res_valid;
      res_prem_r  <= res_prem;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.name_valid   = res_valid_r;
  assign out_ch.name_premium = res_prem_r;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !stg_v_r && !out_v_r)
    else $error("pipeline not empty after reset");

  a_last_posts: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && stg_last_r |=> out_v_r)
    else $error("final byte left input register without a result");

  a_name_restart: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && stg_last_r |=> st_r.tot_cnt == '0 && st_r.seg_cnt == '0 && st_r.letters)
    else $error("name state not cleared after final byte");

  a_seg_le_tot: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.seg_cnt <= st_r.tot_cnt)
    else $error("segment count exceeds total count");

endmodule

FILE: test/name_verdict_checker.sv
`timescale 1ns / 1ps
module name_verdict_checker (
  input  logic      clk,
  input  logic      rst_n,
  anv_in_if         in_ch,
  anv_out_if        out_ch,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int        fail_count,
  output int        pending,
  output int        names_done,
  output int        valid_seen,
  output int        premium_seen
);
  import anv_pkg::*;

  localparam logic [8:0] LEN_SAT = 9'd511;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_Z    = 8'h7A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef struct packed {
    logic ok;
    logic prem;
  } verdict_t;

  verdict_t verdicts_due[$];

  logic [7:0] lim_min, lim_max, lim_prem;
  logic [8:0] name_len, seg_len;
  logic [7:0] prior_ch;
  logic       rule_broken, all_lower;

  function automatic logic lower_ch(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic start_ok(input logic [7:0] c);
    return lower_ch(c) || (c == CH_UNDER);
  endfunction

  function automatic logic end_ok(input logic [7:0] c);
    return start_ok(c) || ((c >= CH_0) && (c <= CH_9));
  endfunction

  function automatic logic mid_ok(input logic [7:0] c);
    return end_ok(c) || (c == CH_HYPHEN);
  endfunction

  function automatic logic seg_short(input logic [8:0] len, input logic [7:0] tail);
    return (len == 9'd0) || (len < {1'b0, lim_min}) || !end_ok(tail);
  endfunction

  task automatic clear_name();
    name_len    = '0;
    seg_len     = '0;
    prior_ch    = '0;
    rule_broken = 1'b0;
    all_lower   = 1'b1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Fold one accepted byte into the name state; queue a verdict on the last.
  task automatic fold_byte(input logic [7:0] c, input logic last);
    logic [8:0] tot, seg;
    logic       broke, lows;
    verdict_t   v;
    broke = rule_broken;
    lows  = all_lower && lower_ch(c);
    tot   = (name_len == LEN_SAT) ? LEN_SAT : name_len + 9'd1;
    seg   = seg_len;
    if (c == CH_DOT) begin
      if (seg_short(seg, prior_ch)) broke = 1'b1;
      if (last) broke = 1'b1;
      seg = '0;
    end else begin
      if (seg == 9'd0) begin
        if (!start_ok(c)) broke = 1'b1;
      end else if (!mid_ok(c)) begin
        broke = 1'b1;
      end
      seg = (seg == LEN_SAT) ? LEN_SAT : seg + 9'd1;
      if (last && seg_short(seg, c)) broke = 1'b1;
    end
    if (last) begin
      v.ok   = !broke && (tot >= {1'b0, lim_min}) && (tot <= {1'b0, lim_max});
      v.prem = lows && (tot >= {1'b0, lim_min}) && (tot <= {1'b0, lim_prem});
      verdicts_due.insert(verdicts_due.size(), v);
      clear_name();
    end else begin
      name_len    = tot;
      seg_len     = seg;
      prior_ch    = c;
      rule_broken = broke;
      all_lower   = lows;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      lim_min  = MIN_LEN_RST;
      lim_max  = MAX_LEN_RST;
      lim_prem = PREM_LEN_RST;
      clear_name();
      verdicts_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result valid=%0b premium=%0b",
                                    out_ch.name_valid, out_ch.name_premium));
        end else begin
          want = verdicts_due.pop_front();
          names_done++;
          if (want.ok) valid_seen++;
          if (want.prem) premium_seen++;
          if (out_ch.name_valid !== want.ok)
            report_mismatch($sformatf("name %0d: name_valid %b, want %b",
                                      names_done, out_ch.name_valid, want.ok));
          if (out_ch.name_premium !== want.prem)
            report_mismatch($sformatf("name %0d: name_premium %b, want %b",
                                      names_done, out_ch.name_premium, want.prem));
        end
      end
      if (in_ch.valid && in_ch.ready) fold_byte(in_ch.char_byte, in_ch.is_last);
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_LEN:  lim_min  = cfg_wdata;
          REG_MAX_LEN:  lim_max  = cfg_wdata;
          REG_PREM_LEN: lim_prem = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = verdicts_due.size();
  end

endmodule

FILE: test/account_name_validator_tb.sv
`timescale 1ns / 1ps
module account_name_validator_tb;
  import anv_pkg::*;

  // Index past the end of the register map; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum int {POS_HEAD, POS_BODY, POS_TAIL} seg_pos_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MIN_LEN;
  logic [7:0] cfg_wdata = '0;
  logic       rx_ready = 1'b0;
  bit         steady = 1'b0;

  int fail_count, pending, names_done, valid_seen, premium_seen;
  int bytes_sent = 0;
  int settings_run = 1;
  int unsigned cur_min = 32'(MIN_LEN_RST);

  logic [7:0] name_buf[$];

  anv_in_if  req_ch ();
  anv_out_if res_ch ();

  assign res_ch.ready = rx_ready;

  account_name_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  name_verdict_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (req_ch),
    .out_ch       (res_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .names_done   (names_done),
    .valid_seen   (valid_seen),
    .premium_seen (premium_seen)
  );

  always #1 clk = ~clk;

  // Stall the result side in about 28 percent of cycles, except in the steady stretch.
  always @(negedge clk) begin
    rx_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #200_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic append_byte(input logic [7:0] c);
    name_buf.insert(name_buf.size(), c);
  endtask

  // Present one request and hold it until the block takes it. Entered and left
  // at a falling edge; valid stays high into the next request unless a random idle gap is inserted.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!steady && $urandom_range(0, 99) < 28) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.char_byte = c;
    req_ch.is_last   = last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_buf();
    for (int i = 0; i < name_buf.size(); i++)
      send_byte(name_buf[i], i == name_buf.size() - 1);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    send_buf();
  endtask

  task automatic send_letters(input int unsigned n);
    name_buf.delete();
    repeat (n) append_byte(8'h61 + 8'($urandom_range(0, 25)));
    send_buf();
  endtask

  // Hold off until every verdict is in, then give the pipeline time to empty
  // of non-final bytes before touching a register.
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == REG_MIN_LEN) cur_min = 32'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(input logic [7:0] mn, input logic [7:0] mx, input logic [7:0] pr);
    drain();
    write_reg(REG_MIN_LEN, mn);
    write_reg(REG_MAX_LEN, mx);
    write_reg(REG_PREM_LEN, pr);
    settings_run++;
  endtask

  function automatic logic [7:0] pick_char(input seg_pos_t pos, input bit plain);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (plain || r < 60) return 8'h61 + 8'($urandom_range(0, 25));
    if (pos == POS_HEAD) return CH_UNDER;
    if (r < 82) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 91 || pos == POS_TAIL) return CH_UNDER;
    return CH_HYPHEN;
  endfunction

  // Build one name: mostly well-formed dotted names sized around the current
  // minimum, some of them broken afterwards, and a share of raw byte noise.
  task automatic build_name();
    int unsigned kind, nseg, seg_len, lo, hi, spot;
    bit plain;
    seg_pos_t pos;
    name_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    plain = ($urandom_range(0, 99) < 35);
    nseg  = plain ? 1 : $urandom_range(1, 3);
    lo    = (cur_min > 1) ? cur_min - 1 : 1;
    hi    = cur_min + 3;
    for (int s = 0; s < nseg; s++) begin
      if (s != 0) append_byte(CH_DOT);
      seg_len = $urandom_range(lo, hi);
      for (int k = 0; k < seg_len; k++) begin
        pos = (k == 0) ? POS_HEAD : ((k == seg_len - 1) ? POS_TAIL : POS_BODY);
        append_byte(pick_char(pos, plain));
      end
    end
    if (kind >= 80) begin
      // Break it: stray byte, doubled or leading dot, trailing dot, bad head.
      spot = $urandom_range(0, name_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: name_buf[spot] = 8'($urandom_range(0, 255));
        1: name_buf.insert(spot, CH_DOT);
        2: append_byte(CH_DOT);
        default: name_buf.push_front($urandom_range(0, 1) ? CH_HYPHEN : 8'h37);
      endcase
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_name();
      send_buf();
    end
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.char_byte = '0;
    req_ch.is_last   = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed names under the reset limits (3, 32, 8).
    send_text("abc");             // shortest valid, premium
    send_text("ab");              // too short
    send_byte(8'hFF, 1'b1);       // top byte value, alone
    send_byte(8'h00, 1'b1);       // bottom byte value, alone
    send_text(".ab");             // leading dot
    send_text("ab.");             // trailing dot
    send_text("_a9");             // valid, not premium
    send_text("-ab");             // hyphen cannot start a segment
    send_text("ab-");             // hyphen cannot end a segment
    name_buf = '{8'h61, 8'h80, 8'h62};
    send_buf();                   // high byte in the middle
    req_ch.valid = 1'b0;

    run_random(60);

    // Widest window; also poke the unused index and expect no effect.
    set_limits(8'd1, 8'd255, 8'd255);
    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
    send_text("a.b");
    run_random(40);

    // All limits zero: length checks on the minimum pass, nothing is valid.
    set_limits(8'd0, 8'd0, 8'd0);
    run_random(30);

    // Back-to-back stretch with no idling on either side.
    set_limits(8'd2, 8'd12, 8'd6);
    steady = 1'b1;
    run_random(80);
    drain();
    steady = 1'b0;

    set_limits(8'($urandom_range(1, 6)), 8'($urandom_range(6, 40)),
               8'($urandom_range(0, 20)));
    run_random(50);

    // Top minimum: a short name fails whatever else holds.
    set_limits(8'd255, 8'd255, 8'd255);
    send_letters(20);

    // Long names against the maximum: exact fit, then one over.
    set_limits(8'd30, 8'd40, 8'd40);
    send_letters(40);
    send_letters(41);

    set_limits(8'd4, 8'd20, 8'd0);
    run_random(30);

    // Wait out the last verdicts, then watch for stray results.
    drain();
    repeat (8) @(negedge clk);

    $display("Covered %0d names (%0d valid, %0d premium) from %0d bytes over %0d limit sets.",
             names_done, valid_seen, premium_seen, bytes_sent, settings_run);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
